// ===== design/stq_pkg.sv =====
// Shared types and codes for the sorted timer event queue.
package stq_pkg;

    // Widths of the fixed port fields.
    localparam int unsigned PORT_TIME_WIDTH = 32;
    localparam int unsigned COUNT_FIELD_WIDTH = 5;

    // Request operation codes.
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_CHECK  = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // Response status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Non-time part of one queue entry.
    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  op_type;
        logic [7:0]  op_name;
    } tag_t;

    // One request.
    typedef struct packed {
        func_t                      func;
        logic [15:0]                pid;
        logic [7:0]                 op_type_code;
        logic [7:0]                 op_name_code;
        logic [PORT_TIME_WIDTH-1:0] ending_time;
        logic [PORT_TIME_WIDTH-1:0] current_time;
    } req_t;

    // One response.
    typedef struct packed {
        logic                         pending;
        logic                         head_valid;
        logic [15:0]                  head_pid;
        logic [7:0]                   head_op_type;
        logic [7:0]                   head_op_name;
        logic [PORT_TIME_WIDTH-1:0]   head_time;
        logic [COUNT_FIELD_WIDTH-1:0] entry_count;
        status_t                      status;
    } rsp_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic remove;
    } cmd_t;

endpackage

// ===== design/stq_cell.sv =====
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module stq_cell #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  stq_pkg::cmd_t         cmd,
    input  logic                  occupied,
    input  stq_pkg::tag_t         new_tag,
    input  logic [TIME_WIDTH-1:0] new_time,
    input  logic                  left_gt,
    input  stq_pkg::tag_t         left_tag,
    input  logic [TIME_WIDTH-1:0] left_time,
    input  stq_pkg::tag_t         right_tag,
    input  logic [TIME_WIDTH-1:0] right_time,
    output logic                  gt,
    output stq_pkg::tag_t         tag,
    output logic [TIME_WIDTH-1:0] time_val,
    output stq_pkg::tag_t         tag_next,
    output logic [TIME_WIDTH-1:0] time_next
);

    stq_pkg::tag_t         tag_reg;
    logic [TIME_WIDTH-1:0] time_reg;

    // This slot holds an entry that sorts after the new one.
    assign gt = occupied && (time_reg > new_time);

    // Insert shifts later entries right; remove shifts everything left.
    always_comb
    begin
        tag_next  = tag_reg;
        time_next = time_reg;
        if (cmd.insert)
        begin
            if (left_gt)
            begin
                tag_next  = left_tag;
                time_next = left_time;
            end
            else if (gt || !occupied)
            begin
                tag_next  = new_tag;
                time_next = new_time;
            end
        end
        else if (cmd.remove)
        begin
            tag_next  = right_tag;
            time_next = right_time;
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        time_reg <= time_next;
    end

    assign tag      = tag_reg;
    assign time_val = time_reg;

endmodule

// ===== design/sorted_timer_event_queue_core.sv =====
// Top level of the sorted timer event queue built as a row of shifting cells.
// A request's response is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while responses are taken; the cell row
// inserts or pops an entry, and a clear only resets the entry count.
// A new request is accepted while the held response is taken in the same cycle.
// Reset empties the queue and drops any held response; entry contents are not cleared.
module sorted_timer_event_queue_core #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  stq_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output stq_pkg::rsp_t rsp_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rsp_valid_reg;
    stq_pkg::rsp_t         rsp_data_reg;
    stq_pkg::rsp_t         rsp_data_next;
    stq_pkg::status_t      status_next;
    stq_pkg::cmd_t         cmd;
    stq_pkg::tag_t         new_tag;
    logic [TIME_WIDTH-1:0] new_time;
    logic [TIME_WIDTH-1:0] now_time;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  head_valid;

    logic                  gt_q      [QUEUE_DEPTH];
    stq_pkg::tag_t         tag_q     [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] time_q    [QUEUE_DEPTH];
    stq_pkg::tag_t         tag_nx    [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] time_nx   [QUEUE_DEPTH];

    // Handshake: take a request whenever the response slot frees up.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // Request payload in internal form.
    assign new_tag.pid     = req_data.pid;
    assign new_tag.op_type = req_data.op_type_code;
    assign new_tag.op_name = req_data.op_name_code;
    assign new_time        = TIME_WIDTH'(req_data.ending_time);
    assign now_time        = TIME_WIDTH'(req_data.current_time);

    // Command to the cell row.
    assign cmd.insert = accept && (req_data.func == stq_pkg::FUNC_INSERT) && !full;
    assign cmd.remove = accept && (req_data.func == stq_pkg::FUNC_REMOVE) && !empty;

    // Row of cells; slot 0 is the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  l_gt;
        stq_pkg::tag_t         l_tag;
        logic [TIME_WIDTH-1:0] l_time;
        stq_pkg::tag_t         r_tag;
        logic [TIME_WIDTH-1:0] r_time;

        if (i == 0)
        begin : g_first
            assign l_gt   = 1'b0;
            assign l_tag  = new_tag;
            assign l_time = new_time;
        end
        else
        begin : g_mid
            assign l_gt   = gt_q[i-1];
            assign l_tag  = tag_q[i-1];
            assign l_time = time_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_tag  = tag_q[i];
            assign r_time = time_q[i];
        end
        else
        begin : g_inner
            assign r_tag  = tag_q[i+1];
            assign r_time = time_q[i+1];
        end

        stq_cell #(
            .TIME_WIDTH(TIME_WIDTH)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (CW'(i) < count_reg),
            .new_tag   (new_tag),
            .new_time  (new_time),
            .left_gt   (l_gt),
            .left_tag  (l_tag),
            .left_time (l_time),
            .right_tag (r_tag),
            .right_time(r_time),
            .gt        (gt_q[i]),
            .tag       (tag_q[i]),
            .time_val  (time_q[i]),
            .tag_next  (tag_nx[i]),
            .time_next (time_nx[i])
        );
    end

    // Entry count and status after the request.
    always_comb
    begin
        count_next  = count_reg;
        status_next = stq_pkg::STATUS_OK;
        if (accept)
        begin
            unique case (req_data.func)
                stq_pkg::FUNC_INSERT:
                begin
                    if (full)
                        status_next = stq_pkg::STATUS_FULL;
                    else
                        count_next = count_reg + CW'(1);
                end
                stq_pkg::FUNC_REMOVE:
                begin
                    if (empty)
                        status_next = stq_pkg::STATUS_EMPTY;
                    else
                        count_next = count_reg - CW'(1);
                end
                stq_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Response built from the head as it stands after the request.
    assign head_valid = (count_next != '0);

    always_comb
    begin
        rsp_data_next.head_valid   = head_valid;
        rsp_data_next.pending      = head_valid && (now_time >= time_nx[0]);
        rsp_data_next.head_pid     = head_valid ? tag_nx[0].pid : '0;
        rsp_data_next.head_op_type = head_valid ? tag_nx[0].op_type : '0;
        rsp_data_next.head_op_name = head_valid ? tag_nx[0].op_name : '0;
        rsp_data_next.head_time    = head_valid ?
                                     stq_pkg::PORT_TIME_WIDTH'(time_nx[0]) : '0;
        rsp_data_next.entry_count  = stq_pkg::COUNT_FIELD_WIDTH'(count_next);
        rsp_data_next.status       = status_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== design/stq_checker.sv =====
// Port-level checks for the sorted timer event queue, bound to the top level.
module stq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input stq_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input stq_pkg::rsp_t rsp_data
);

    // A stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

    // Every accepted request yields a response in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
    else $error("no response after accepted request");

    // An empty queue reports no head and nothing pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.head_valid |->
            !rsp_data.pending && (rsp_data.head_time == '0) && (rsp_data.head_pid == '0))
    else $error("empty queue shows a head");

    // A clear leaves the queue empty with ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.func == stq_pkg::FUNC_CLEAR) |=>
            (rsp_data.entry_count == '0) && !rsp_data.head_valid &&
            (rsp_data.status == stq_pkg::STATUS_OK))
    else $error("clear did not empty the queue");

endmodule

bind sorted_timer_event_queue_core stq_checker u_stq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted timer event queue core.
module tb;

    localparam int QDEPTH          = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 620;
    localparam int DIRECTED_ROWS   = 18;

    // Request mixes used by the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_NOISE
    } mix_t;

    // One line of the directed table; want is used only when typed is set.
    typedef struct {
        stq_pkg::req_t req;
        int unsigned   reps;
        bit            typed;
        stq_pkg::rsp_t want;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    stq_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_ready;
    stq_pkg::rsp_t rsp_data;

    // Predicted queue contents, head at index zero.
    logic [31:0]   model_time [QDEPTH];
    stq_pkg::tag_t model_tag [QDEPTH];
    int            model_count = 0;

    // Queue views still owed by the block, oldest first.
    stq_pkg::rsp_t awaited_views [$];
    int            errors = 0;
    bit            idle_on = 1'b1;
    int unsigned   cycles = 0;
    stim_row_t     dir_rows [DIRECTED_ROWS];

    sorted_timer_event_queue_core #(
        .QUEUE_DEPTH(QDEPTH),
        .TIME_WIDTH (32)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    // Apply one request to the predicted queue and return the view after it.
    function automatic stq_pkg::rsp_t queue_apply(input stq_pkg::req_t r);
        stq_pkg::rsp_t    view;
        stq_pkg::status_t st;
        int               pos;
        int               k;
        st = stq_pkg::STATUS_OK;
        case (r.func)
            stq_pkg::FUNC_INSERT:
            begin
                if (model_count >= QDEPTH)
                begin
                    st = stq_pkg::STATUS_FULL;
                end
                else
                begin
                    // Equal times keep arrival order: skip every entry not later.
                    pos = 0;
                    while (pos < model_count && model_time[pos] <= r.ending_time) pos++;
                    for (k = model_count; k > pos; k--)
                    begin
                        model_time[k] = model_time[k - 1];
                        model_tag[k]  = model_tag[k - 1];
                    end
                    model_time[pos]        = r.ending_time;
                    model_tag[pos].pid     = r.pid;
                    model_tag[pos].op_type = r.op_type_code;
                    model_tag[pos].op_name = r.op_name_code;
                    model_count++;
                end
            end
            stq_pkg::FUNC_REMOVE:
            begin
                if (model_count == 0)
                begin
                    st = stq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    for (k = 0; k + 1 < model_count; k++)
                    begin
                        model_time[k] = model_time[k + 1];
                        model_tag[k]  = model_tag[k + 1];
                    end
                    model_count--;
                end
            end
            stq_pkg::FUNC_CLEAR:
            begin
                model_count = 0;
            end
            default:
            begin
            end
        endcase

        // Head fields read as zero on an empty queue.
        view             = '0;
        view.status      = st;
        view.entry_count = 5'(model_count);
        if (model_count > 0)
        begin
            view.head_valid   = 1'b1;
            view.head_pid     = model_tag[0].pid;
            view.head_op_type = model_tag[0].op_type;
            view.head_op_name = model_tag[0].op_name;
            view.head_time    = model_time[0];
            view.pending      = r.current_time >= model_time[0];
        end
        return view;
    endfunction

    function automatic stq_pkg::rsp_t make_view(input bit pend, input bit hv,
                                                input logic [15:0] pid,
                                                input logic [7:0] ty, input logic [7:0] nm,
                                                input logic [31:0] t, input logic [4:0] cnt,
                                                input stq_pkg::status_t st);
        stq_pkg::rsp_t view;
        view.pending      = pend;
        view.head_valid   = hv;
        view.head_pid     = pid;
        view.head_op_type = ty;
        view.head_op_name = nm;
        view.head_time    = t;
        view.entry_count  = cnt;
        view.status       = st;
        return view;
    endfunction

    function automatic stim_row_t make_row(input stq_pkg::func_t f, input logic [15:0] pid,
                                           input logic [7:0] ty, input logic [7:0] nm,
                                           input logic [31:0] et, input logic [31:0] now,
                                           input int unsigned reps, input bit typed,
                                           input stq_pkg::rsp_t want);
        stim_row_t row;
        row.req.func         = f;
        row.req.pid          = pid;
        row.req.op_type_code = ty;
        row.req.op_name_code = nm;
        row.req.ending_time  = et;
        row.req.current_time = now;
        row.reps             = reps;
        row.typed            = typed;
        row.want             = want;
        return row;
    endfunction

    // Random request drawn from a mix, with times aimed at ties and at the head.
    function automatic stq_pkg::req_t rand_request(input mix_t mode);
        stq_pkg::req_t r;
        int unsigned   roll;
        r.pid          = 16'($urandom);
        r.op_type_code = 8'($urandom);
        r.op_name_code = 8'($urandom);
        roll = $urandom_range(0, 19);
        case (mode)
            MIX_FILL:
                r.func = (roll < 17) ? stq_pkg::FUNC_INSERT :
                         (roll < 19) ? stq_pkg::FUNC_CHECK : stq_pkg::FUNC_REMOVE;
            MIX_DRAIN:
                r.func = (roll < 14) ? stq_pkg::FUNC_REMOVE :
                         (roll < 18) ? stq_pkg::FUNC_CHECK :
                         (roll < 19) ? stq_pkg::FUNC_INSERT : stq_pkg::FUNC_CLEAR;
            MIX_BALANCED:
                r.func = (roll < 8)  ? stq_pkg::FUNC_INSERT :
                         (roll < 12) ? stq_pkg::FUNC_CHECK :
                         (roll < 19) ? stq_pkg::FUNC_REMOVE : stq_pkg::FUNC_CLEAR;
            default:
                r.func = stq_pkg::func_t'($urandom_range(0, 3));
        endcase

        case ($urandom_range(0, 3))
            0: r.ending_time = $urandom_range(0, 7);
            1: r.ending_time = 32'hFFFF_FFF8 | $urandom_range(0, 7);
            2: r.ending_time = (model_count > 0) ?
                               model_time[$urandom_range(0, model_count - 1)] : $urandom;
            default: r.ending_time = $urandom;
        endcase

        if (model_count == 0)
        begin
            r.current_time = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: r.current_time = $urandom;
                1: r.current_time = model_time[0];
                2: r.current_time = model_time[0] - 1;
                default: r.current_time = model_time[0] + 1;
            endcase
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Match one taken response against the oldest owed view.
    task automatic check_response(input stq_pkg::rsp_t got);
        stq_pkg::rsp_t want;
        if (awaited_views.size() == 0)
        begin
            errors++;
            $display("%0t: response expected none, actual %p", $time, got);
        end
        else
        begin
            want = awaited_views.pop_front();
            compare_field("pending", want.pending, got.pending);
            compare_field("head_valid", want.head_valid, got.head_valid);
            compare_field("head_pid", want.head_pid, got.head_pid);
            compare_field("head_op_type", want.head_op_type, got.head_op_type);
            compare_field("head_op_name", want.head_op_name, got.head_op_name);
            compare_field("head_time", want.head_time, got.head_time);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("status", want.status, got.status);
        end
    endtask

    // Present one request after a random gap and record its view once taken.
    task automatic issue(input stq_pkg::req_t r, input bit typed, input stq_pkg::rsp_t want);
        int unsigned   gap;
        stq_pkg::rsp_t view;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_ready !== 1'b1);
        view = queue_apply(r);
        awaited_views.push_back(typed ? want : view);
        @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
        $display("sorted_timer_event_queue_core: mismatch");
        $finish;
    end

    // Response side: random stalls before each response is taken.
    initial
    begin
        int unsigned stall;
        rsp_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            check_response(rsp_data);
            @(negedge clk);
        end
    end

    // Request side: reset, directed table, then random mixes.
    initial
    begin
        mix_t        mode;
        int unsigned pick;
        int          n;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;

        // Empty queue, both extremes of every entry field, equal times, full and clear.
        dir_rows[0]  = make_row(stq_pkg::FUNC_CHECK, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_OK));
        dir_rows[1]  = make_row(stq_pkg::FUNC_REMOVE, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_EMPTY));
        dir_rows[2]  = make_row(stq_pkg::FUNC_CLEAR, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_OK));
        dir_rows[3]  = make_row(stq_pkg::FUNC_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFE, 1, 1,
                                make_view(0, 1, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 5'd1,
                                          stq_pkg::STATUS_OK));
        dir_rows[4]  = make_row(stq_pkg::FUNC_CHECK, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 1,
                                make_view(1, 1, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 5'd1,
                                          stq_pkg::STATUS_OK));
        dir_rows[5]  = make_row(stq_pkg::FUNC_INSERT, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0, 1, 1,
                                make_view(1, 1, 16'h0, 8'h0, 8'h0, 32'h0, 5'd2,
                                          stq_pkg::STATUS_OK));
        dir_rows[6]  = make_row(stq_pkg::FUNC_INSERT, 16'h0001, 8'h01, 8'h80, 32'h0, 32'h0,
                                1, 0, '0);
        dir_rows[7]  = make_row(stq_pkg::FUNC_INSERT, 16'h5A5A, 8'hA5, 8'h5A, 32'h8000_0000,
                                32'h7FFF_FFFF, 1, 0, '0);
        dir_rows[8]  = make_row(stq_pkg::FUNC_REMOVE, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0,
                                1, 0, '0);
        dir_rows[9]  = make_row(stq_pkg::FUNC_INSERT, 16'h0F0F, 8'h3C, 8'hC3, 32'h1000,
                                32'h0FFF, 13, 0, '0);
        dir_rows[10] = make_row(stq_pkg::FUNC_INSERT, 16'h1234, 8'h12, 8'h34, 32'h5, 32'h0,
                                1, 1,
                                make_view(1, 1, 16'h0001, 8'h01, 8'h80, 32'h0, 5'd16,
                                          stq_pkg::STATUS_FULL));
        dir_rows[11] = make_row(stq_pkg::FUNC_CHECK, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 0, '0);
        dir_rows[12] = make_row(stq_pkg::FUNC_REMOVE, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0,
                                1, 0, '0);
        dir_rows[13] = make_row(stq_pkg::FUNC_CLEAR, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_OK));
        dir_rows[14] = make_row(stq_pkg::FUNC_CHECK, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_OK));
        dir_rows[15] = make_row(stq_pkg::FUNC_INSERT, 16'hAAAA, 8'h55, 8'hAA, 32'h0,
                                32'hFFFF_FFFF, 1, 0, '0);
        dir_rows[16] = make_row(stq_pkg::FUNC_REMOVE, 16'h0, 8'h0, 8'h0, 32'h0,
                                32'hFFFF_FFFF, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_OK));
        dir_rows[17] = make_row(stq_pkg::FUNC_REMOVE, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0, 1, 1,
                                make_view(0, 0, 16'h0, 8'h0, 8'h0, 32'h0, 5'd0,
                                          stq_pkg::STATUS_EMPTY));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            repeat (dir_rows[i].reps)
                issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: a new mix every 24 requests, with stretches of no idling.
        mode = MIX_BALANCED;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 150 == 0)
            begin
                // Hold off until the block has answered everything.
                req_valid <= 1'b0;
                wait (awaited_views.size() == 0);
                @(negedge clk);
            end
            if (n % 24 == 0)
            begin
                pick = $urandom_range(0, 9);
                mode = (pick < 3) ? MIX_FILL : (pick < 6) ? MIX_DRAIN :
                       (pick < 9) ? MIX_BALANCED : MIX_NOISE;
            end
            idle_on = ((n / 40) % 3) != 2;
            issue(rand_request(mode), 1'b0, '0);
        end
        req_valid <= 1'b0;
        idle_on = 1'b1;

        // Drain, then allow for the registered response.
        wait (awaited_views.size() == 0);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("sorted_timer_event_queue_core: match");
        else
            $display("sorted_timer_event_queue_core: mismatch");
        $finish;
    end

endmodule
